### rtl/core/nfrm_pkg.sv
// ----------------------------------------------------------------------------
// nfrm_pkg
// Types and constants shared by the read-response parser and the touch report
// logic of the register mirror core.
// ----------------------------------------------------------------------------
package nfrm_pkg;

  localparam logic [7:0] START_BYTE = 8'hC0;
  localparam int unsigned TOUCH_BIT = 7;

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned PTR_W  = 7;

  // Mirror entries that feed the touch report.
  localparam logic [PTR_W-1:0] ADDR_STAT1 = 7'd1;
  localparam logic [PTR_W-1:0] ADDR_X_HI  = 7'd3;
  localparam logic [PTR_W-1:0] ADDR_X_LO  = 7'd4;
  localparam logic [PTR_W-1:0] ADDR_Y_HI  = 7'd5;
  localparam logic [PTR_W-1:0] ADDR_Y_LO  = 7'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_read;
  } in_item_t;

  typedef struct packed {
    logic        touching;
    logic        position_valid;
    logic [15:0] x_position;
    logic [15:0] y_position;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_CNT_HI,
    PH_CNT_LO,
    PH_DATA_HI,
    PH_DATA_LO,
    PH_IDLE
  } phase_t;

  // Parser to report logic: one mirror write and the frame-complete strobe.
  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             frame_done;
  } mirror_ctl_t;

endpackage

### rtl/core/nfrm_parser.sv
// ----------------------------------------------------------------------------
// nfrm_parser
// Frame parser: hunts for the start byte, assembles address and count from
// nibble pairs and issues one mirror write per data pair.
// ----------------------------------------------------------------------------
module nfrm_parser import nfrm_pkg::*; #(
  parameter int unsigned MIRROR_ENTRIES = 113
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_item_t    item,
  output mirror_ctl_t ctl
);

  phase_t              phase_r, phase_nxt;
  logic [7:0]          hold_r, hold_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]    wptr_r, wptr_nxt;

  logic [ADDR_W-1:0]   pair;
  logic                addr_bad;
  logic                at_end;

  assign pair     = {hold_r, 4'h0} | {4'h0, item.rx_byte};
  assign addr_bad = pair >= ADDR_W'(MIRROR_ENTRIES);
  assign at_end   = ({1'b0, wptr_r} + 8'd1) >= 8'(MIRROR_ENTRIES);

  always_comb begin
    phase_nxt = phase_r;
    hold_nxt  = hold_r;
    cnt_nxt   = cnt_r;
    wptr_nxt  = wptr_r;
    case (phase_r)
      PH_HUNT: begin
        if (item.rx_byte == START_BYTE) begin
          phase_nxt = PH_ADDR_HI;
        end
      end
      PH_ADDR_HI: begin
        hold_nxt  = item.rx_byte;
        phase_nxt = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        if (addr_bad) begin
          phase_nxt = PH_IDLE;
        end else begin
          wptr_nxt  = pair[PTR_W-1:0];
          phase_nxt = PH_CNT_HI;
        end
      end
      PH_CNT_HI: begin
        hold_nxt  = item.rx_byte;
        phase_nxt = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        cnt_nxt   = pair;
        phase_nxt = (pair == '0) ? PH_IDLE : PH_DATA_HI;
      end
      PH_DATA_HI: begin
        hold_nxt  = item.rx_byte;
        phase_nxt = PH_DATA_LO;
      end
      PH_DATA_LO: begin
        cnt_nxt = cnt_r - ADDR_W'(1);
        if (cnt_r == ADDR_W'(1) || at_end) begin
          phase_nxt = PH_IDLE;
        end else begin
          wptr_nxt  = wptr_r + PTR_W'(1);
          phase_nxt = PH_DATA_HI;
        end
      end
      default: begin
      end
    endcase
    // The last byte of a read is still parsed, then the parser rearms.
    if (item.end_of_read) begin
      phase_nxt = PH_HUNT;
    end
  end

  always_comb begin
    ctl.wr_en      = 1'b0;
    ctl.wr_addr    = wptr_r;
    ctl.wr_data    = pair[7:0];
    ctl.frame_done = 1'b0;
    case (phase_r)
      PH_CNT_LO: begin
        ctl.frame_done = step && (pair == '0);
      end
      PH_DATA_LO: begin
        ctl.wr_en      = step && ({1'b0, wptr_r} < 8'(MIRROR_ENTRIES));
        ctl.frame_done = step && (cnt_r == ADDR_W'(1) || at_end);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      hold_r  <= '0;
      cnt_r   <= '0;
      wptr_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      cnt_r   <= cnt_nxt;
      wptr_r  <= wptr_nxt;
    end
  end

endmodule

### rtl/core/nfrm_report.sv
// ----------------------------------------------------------------------------
// nfrm_report
// Holds the mirror bytes that the touch report reads and forms the report
// from them, with the write of the current cycle already applied.
// ----------------------------------------------------------------------------
module nfrm_report import nfrm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mirror_ctl_t ctl,
  output out_item_t   report
);

  // Only status register 1 and the four position bytes are ever read back,
  // so those are the only mirror entries kept in flops.
  logic [7:0] stat1_r, stat1_nxt;
  logic [7:0] x_hi_r, x_hi_nxt;
  logic [7:0] x_lo_r, x_lo_nxt;
  logic [7:0] y_hi_r, y_hi_nxt;
  logic [7:0] y_lo_r, y_lo_nxt;

  always_comb begin
    stat1_nxt = (ctl.wr_en && ctl.wr_addr == ADDR_STAT1) ? ctl.wr_data : stat1_r;
    x_hi_nxt  = (ctl.wr_en && ctl.wr_addr == ADDR_X_HI)  ? ctl.wr_data : x_hi_r;
    x_lo_nxt  = (ctl.wr_en && ctl.wr_addr == ADDR_X_LO)  ? ctl.wr_data : x_lo_r;
    y_hi_nxt  = (ctl.wr_en && ctl.wr_addr == ADDR_Y_HI)  ? ctl.wr_data : y_hi_r;
    y_lo_nxt  = (ctl.wr_en && ctl.wr_addr == ADDR_Y_LO)  ? ctl.wr_data : y_lo_r;
  end

  always_comb begin
    report.touching       = stat1_nxt[TOUCH_BIT];
    report.x_position     = {x_hi_nxt, x_lo_nxt};
    report.y_position     = {y_hi_nxt, y_lo_nxt};
    report.position_valid = report.touching && (report.x_position != '0) &&
                            (report.y_position != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat1_r <= '0;
      x_hi_r  <= '0;
      x_lo_r  <= '0;
      y_hi_r  <= '0;
      y_lo_r  <= '0;
    end else begin
      stat1_r <= stat1_nxt;
      x_hi_r  <= x_hi_nxt;
      x_lo_r  <= x_lo_nxt;
      y_hi_r  <= y_hi_nxt;
      y_lo_r  <= y_lo_nxt;
    end
  end

endmodule

### rtl/core/nibble_frame_register_mirror_core.sv
// ----------------------------------------------------------------------------
// nibble_frame_register_mirror_core
// Parses a touch controller's read response byte by byte into a register
// mirror and issues a touch report for each completed frame.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | in_data  (in_item_t)
//   out_    | output    | out_valid / out_ready| out_data (out_item_t)
//
// One byte can be taken every cycle while the result register is free or drains.
// A byte is parsed from the input register when it moves on, and the report
// is registered in the result register as the byte that completes the frame is
// parsed. A report that waits in the result register and is not taken in the
// current cycle stalls parsing, and with it the input.
// Reset is synchronous on rst_n and returns the parser to hunting for the
// start byte with the mirrored report bytes cleared.
// ----------------------------------------------------------------------------
module nibble_frame_register_mirror_core import nfrm_pkg::*; #(
  parameter int unsigned MIRROR_ENTRIES = 113
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic        in_valid_r;
  in_item_t    in_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        step;
  mirror_ctl_t ctl;
  out_item_t   report;

  // A parsed byte moves on whenever the result register is free or drains.
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  nfrm_parser #(
    .MIRROR_ENTRIES(MIRROR_ENTRIES)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_data_r),
    .ctl   (ctl)
  );

  nfrm_report u_report (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .report (report)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.frame_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.frame_done) begin
      out_data_r <= report;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
